@@ rtl/snss_pkg.sv @@
`timescale 1ns / 1ps

package snss_pkg;

    localparam int NUM_DIGITS = 4;

    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_DASH  = 8'h40;

    // One formatting request as carried on the input channel
    typedef struct packed {
        logic        allow_minus;
        logic        show_leading_zeros;
        logic [1:0]  start_digit;
        logic [2:0]  field_length;
        logic signed [15:0] number;
    } item_t;

    // Segment bytes, index 0 is the leftmost digit
    typedef logic [NUM_DIGITS-1:0][7:0] segs_t;

    // Segment pattern of one decimal digit, 0bGFEDCBA
    function automatic logic [7:0] digit_segments(input logic [3:0] d);
        logic [7:0] seg;
        unique case (d)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

@@ rtl/snss_format.sv @@
`timescale 1ns / 1ps

module snss_format
    import snss_pkg::*;
(
    input  item_t item,
    output segs_t segs
);

    // Powers of ten indexed by digit count
    localparam logic [4:0][15:0] POW10 = {16'd10000, 16'd1000, 16'd100, 16'd10, 16'd1};

    // Reciprocal constants, exact for magnitudes up to 32768
    localparam logic [31:0] RECIP_10    = 32'd52429;
    localparam logic [31:0] RECIP_100   = 32'd41944;
    localparam logic [31:0] RECIP_1000  = 32'd33555;
    localparam logic [31:0] RECIP_10000 = 32'd26844;

    logic [15:0] raw;
    logic        neg;
    logic [15:0] mag;
    logic [2:0]  len_clamp;
    logic [2:0]  room;
    logic [2:0]  len;
    logic [2:0]  pos3;
    logic [2:0]  end3;
    logic        ovf;
    logic [31:0] prod1, prod2, prod3, prod4;
    logic [4:0][15:0] q;
    logic [3:0][3:0]  dig;

    assign raw = item.number;
    assign neg = raw[15] & item.allow_minus;

    always_comb begin
        if (raw[15]) begin
            mag = item.allow_minus ? (~raw + 16'd1) : 16'd0;
        end else begin
            mag = raw;
        end
    end

    // Field placement: clamp to four digits, then cut at the right edge
    assign len_clamp = (item.field_length > 3'd4) ? 3'd4 : item.field_length;
    assign room      = 3'd4 - {1'b0, item.start_digit};
    assign len       = (len_clamp > room) ? room : len_clamp;
    assign pos3      = {1'b0, item.start_digit};
    assign end3      = pos3 + len;

    // Quotients by constant powers of ten, all in parallel
    assign prod1 = {16'd0, mag} * RECIP_10;
    assign prod2 = {16'd0, mag} * RECIP_100;
    assign prod3 = {16'd0, mag} * RECIP_1000;
    assign prod4 = {16'd0, mag} * RECIP_10000;

    assign q[0] = mag;
    assign q[1] = {3'd0,  prod1[31:19]};
    assign q[2] = {6'd0,  prod2[31:22]};
    assign q[3] = {9'd0,  prod3[31:25]};
    assign q[4] = {12'd0, prod4[31:28]};

    always_comb begin
        logic [15:0] diff;
        for (int j = 0; j < NUM_DIGITS; j++) begin
            diff   = q[j] - ({q[j+1][12:0], 3'd0} + {q[j+1][14:0], 1'b0});
            dig[j] = diff[3:0];
        end
    end

    // Magnitude needs more digits than the field holds
    assign ovf = (mag >= POW10[len]);

    always_comb begin
        logic [2:0] p3;
        logic [2:0] off3;
        logic [1:0] j;
        logic       blank;
        for (int p = 0; p < NUM_DIGITS; p++) begin
            p3    = 3'(p);
            off3  = end3 - 3'd1 - p3;
            j     = off3[1:0];
            blank = (j != 2'd0) && !item.show_leading_zeros && (mag < POW10[{1'b0, j}]);
            if ((p3 >= pos3) && (p3 < end3)) begin
                if (ovf) begin
                    segs[p] = SEG_DASH;
                end else if (blank) begin
                    segs[p] = SEG_BLANK;
                end else begin
                    segs[p] = digit_segments(dig[j]);
                end
                if (neg && (p3 == pos3)) begin
                    segs[p] = SEG_DASH;
                end
            end else begin
                segs[p] = SEG_BLANK;
            end
        end
    end

endmodule

@@ rtl/signed_number_to_seven_segment.sv @@
`timescale 1ns / 1ps
// An accepted item passes the input register, then the result register; the
//   formatter between them is a single combinational pass.
// Throughput: one item per cycle while the output is not back-pressured.
// Reset: aresetn is synchronous and active low; it clears both valid flags only,
//   payload registers keep whatever they held.

module signed_number_to_seven_segment
    import snss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] number, [18:16] field_length, [20:19] start_digit,
    // [21] show_leading_zeros, [22] allow_minus, [23] zero pad
    input  logic [23:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] segments_digit0, [15:8] segments_digit1,
    // [23:16] segments_digit2, [31:24] segments_digit3
    output logic [31:0] m_tdata
);

    // Input stage
    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;
    item_t s_item;

    // Result stage
    logic  out_valid_reg, out_valid_next;
    segs_t out_segs_reg;
    segs_t fmt_segs;

    // The result register frees up when empty or when its transfer completes
    logic advance;

    assign s_item = item_t'(s_tdata[22:0]);

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
        if (advance && in_valid_reg) begin
            out_segs_reg <= fmt_segs;
        end
    end

    // Placement, decimal conversion and segment lookup in one pass
    snss_format u_format (
        .item (in_item_reg),
        .segs (fmt_segs)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_segs_reg;

`ifndef SYNTH
    // A held input item moves into the result register once it frees up
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |=> m_tvalid)
        else $error("input item not moved to result register");

    // A blocked input item is neither lost nor overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("blocked input item changed");

    // Backpressure on the input only when both stages are full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room available");

    // Segment bytes never light the spare bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[7] && !m_tdata[15] && !m_tdata[23] && !m_tdata[31]))
        else $error("bit 7 set in a segment byte");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import snss_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 8;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    signed_number_to_seven_segment i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Glyphs 0..9, 0bGFEDCBA
    logic [7:0] digit_glyph [0:9] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                      8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    item_t pending_items[$];
    segs_t expected_digits[$];
    int    err_count   = 0;
    int    items_in    = 0;
    int    idle_cycles = 0;

    // sender pacing
    int burst_left = 0;
    int gap_left   = 0;

    // receiver pacing
    int rx_mode    = 0;
    int rx_count   = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Expected display for one request
    function automatic segs_t format_display(item_t it);
        segs_t       seg;
        int unsigned len, pos, last, mag, d;
        bit          neg;
        int          k;
        seg = '0;
        len = it.field_length;
        pos = it.start_digit;
        neg = 1'b0;
        if (len > 4) len = 4;
        if (pos + len > 4) len = 4 - pos;
        if (it.number[15]) begin
            if (it.allow_minus) begin
                neg = 1'b1;
                mag = 32'h10000 - {16'h0, it.number};
            end else begin
                mag = 0;
            end
        end else begin
            mag = {16'h0, it.number};
        end
        if (len > 0) begin
            last = pos + len - 1;
            for (k = int'(last); k >= int'(pos); k--) begin
                d = mag % 10;
                mag = mag / 10;
                // blank leading zeros, but never the rightmost field digit
                if (!it.show_leading_zeros && mag == 0 && d == 0 && k != int'(last))
                    seg[k] = SEG_BLANK;
                else
                    seg[k] = digit_glyph[d];
            end
            if (mag > 0) begin
                for (k = int'(pos); k <= int'(last); k++) seg[k] = SEG_DASH;
            end
            if (neg) seg[pos] = SEG_DASH;
        end
        return seg;
    endfunction

    task automatic queue_request(input int num, input int len, input int start,
                                 input bit lz, input bit minus);
        item_t it;
        it.number             = num[15:0];
        it.field_length       = len[2:0];
        it.start_digit        = start[1:0];
        it.show_leading_zeros = lz;
        it.allow_minus        = minus;
        pending_items.push_back(it);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %02h expected %02h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Driver: bursts of transfers separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_digits.push_back(format_display(item_t'(s_tdata[22:0])));
                items_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_tdata  <= {1'b0, pending_items.pop_front()};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern redrawn periodically, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_count++;
            if (rx_count % 64 == 0) rx_mode = $urandom_range(0, 3);
            if (!hold_done && items_in >= 200) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (rx_count % 3) != 0;
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_tvalid && m_tready) begin
                if (expected_digits.size() == 0) begin
                    $display("UNEXPECTED result %08h at %0t", m_tdata, $realtime);
                    err_count++;
                end else begin
                    segs_t want;
                    segs_t got;
                    want = expected_digits.pop_front();
                    got  = segs_t'(m_tdata);
                    if (got[0] !== want[0]) report_mismatch("segments_digit0", got[0], want[0]);
                    if (got[1] !== want[1]) report_mismatch("segments_digit1", got[1], want[1]);
                    if (got[2] !== want[2]) report_mismatch("segments_digit2", got[2], want[2]);
                    if (got[3] !== want[3]) report_mismatch("segments_digit3", got[3], want[3]);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TIMEOUT after %0d idle cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int num;
        int len;
        int sel;

        // directed: extremes, clamping, empty field, sign handling
        queue_request(0, 4, 0, 0, 0);
        queue_request(0, 4, 0, 1, 0);
        queue_request(32767, 4, 0, 0, 0);       // overflow
        queue_request(-32768, 4, 0, 0, 1);      // most negative, overflow + minus
        queue_request(-32768, 4, 0, 0, 0);      // negative shown as zero
        queue_request(-1, 4, 0, 0, 1);
        queue_request(-999, 4, 0, 0, 1);
        queue_request(-1234, 4, 0, 0, 1);       // dash hides the top digit
        queue_request(9999, 4, 0, 1, 0);
        queue_request(10000, 7, 0, 0, 0);       // length above four
        queue_request(123, 0, 2, 0, 1);         // empty field
        queue_request(-5, 0, 0, 1, 1);          // empty field, negative
        queue_request(42, 4, 3, 1, 0);          // cut to one digit, overflow
        queue_request(7, 2, 1, 1, 0);
        queue_request(56, 3, 1, 0, 1);
        queue_request(-7, 2, 2, 0, 1);
        queue_request(100, 3, 1, 0, 0);
        queue_request(5, 1, 3, 0, 0);
        queue_request(-32768, 6, 0, 1, 1);
        queue_request(1000, 5, 1, 0, 1);
        queue_request(-12, 3, 0, 1, 1);
        queue_request(-1, 1, 3, 1, 1);          // one-digit field, negative

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 3);
            case (sel)
                0: num = $urandom;
                1: num = $urandom_range(0, 120);
                2: begin
                    case ($urandom_range(0, 3))
                        0:       num = 10;
                        1:       num = 100;
                        2:       num = 1000;
                        default: num = 10000;
                    endcase
                    num = num + $urandom_range(0, 2) - 1;
                end
                default: num = $urandom_range(0, 99);
            endcase
            if (sel != 0 && $urandom_range(0, 1)) num = -num;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            queue_request(num, len, $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_items.size() == 0 && !s_tvalid);
        wait (expected_digits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_digits.size() != 0) begin
            $display("MISSING %0d results", expected_digits.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/snss_pkg.sv
rtl/snss_format.sv
rtl/signed_number_to_seven_segment.sv
dv/tb_top.sv
